/* rtl/rcld_pkg.sv */
// package for the region cache lru directory: widths, command and status codes,
// the per-slot operation struct and the result struct
// no dependencies
`timescale 1ns / 1ps

package rcld_pkg;

    // defaults for the top-level parameters
    localparam int SLOT_COUNT_DEF  = 16;
    localparam int REGION_BITS_DEF = 21;
    localparam int ADDR_BITS_DEF   = 64;

    // fixed field widths
    localparam int CMD_W    = 3;
    localparam int SIZE_W   = 32;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;
    localparam int OFFSET_W = 21;
    localparam int COUNT_W  = 64;
    localparam int STAMP_W  = 64;

    // command codes
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FILL  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INVAL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FLUSH = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FAIL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BUSY = 2'd2;

    // operation applied to one slot cell in a cycle
    typedef struct packed {
        logic install;  // write tag and stamp, set valid
        logic touch;    // refresh stamp
        logic drop;     // clear valid
        logic flush;    // clear valid
        logic inval;    // clear valid when tag lies in the range
    } cell_op_t;

    // small fields of one result beat
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                hit;
        logic [SLOT_W-1:0]   slot;
        logic                fetch;
        logic                pass;
    } result_t;

endpackage

/* rtl/rcld_cell.sv */
// one slot of the directory: valid bit, region tag, use stamp, and one stage
// of the victim search chain
// depends on rcld_pkg
`timescale 1ns / 1ps

module rcld_cell #(
    parameter int IW       = 4,
    parameter int TW       = 43,
    parameter int CELL_IDX = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rcld_pkg::cell_op_t            op,
    input  logic [TW-1:0]                 cmp_tag,
    input  logic [TW-1:0]                 wr_tag,
    input  logic [rcld_pkg::STAMP_W-1:0]  wr_stamp,
    input  logic [TW-1:0]                 inv_t0,
    input  logic [TW-1:0]                 inv_span,
    input  logic                          tk_valid_in,
    input  logic [IW-1:0]                 tk_idx_in,
    input  logic [rcld_pkg::STAMP_W-1:0]  tk_stamp_in,
    output logic                          tk_valid_out,
    output logic [IW-1:0]                 tk_idx_out,
    output logic [rcld_pkg::STAMP_W-1:0]  tk_stamp_out,
    output logic                          valid,
    output logic                          match
);

    logic                         valid_reg, valid_next;
    logic [TW-1:0]                tag_reg, tag_next;
    logic [rcld_pkg::STAMP_W-1:0] stamp_reg, stamp_next;
    logic                         tk_valid_reg, tk_valid_next;
    logic [IW-1:0]                tk_idx_reg, tk_idx_next;
    logic [rcld_pkg::STAMP_W-1:0] tk_stamp_reg, tk_stamp_next;
    logic [TW-1:0]                tag_off;
    logic                         take;

    // tag compare against the incoming address
    assign match = valid_reg && (tag_reg == cmp_tag);
    assign valid = valid_reg;

    // distance from range start, wraps round the tag space
    assign tag_off = tag_reg - inv_t0;

    // slot state update
    always_comb
    begin
        valid_next = valid_reg;
        tag_next   = tag_reg;
        stamp_next = stamp_reg;
        if (op.flush || op.drop)
        begin
            valid_next = 1'b0;
        end
        if (op.inval && valid_reg && (tag_off <= inv_span))
        begin
            valid_next = 1'b0;
        end
        if (op.install)
        begin
            valid_next = 1'b1;
            tag_next   = wr_tag;
        end
        if (op.install || op.touch)
        begin
            stamp_next = wr_stamp;
        end
    end

    // search stage: the first cell seeds the candidate, later ones keep the
    // earlier slot on a tie
    assign take = (CELL_IDX == 0) || (stamp_reg < tk_stamp_in);

    always_comb
    begin
        tk_valid_next = tk_valid_in;
        tk_idx_next   = tk_idx_in;
        tk_stamp_next = tk_stamp_in;
        if (take)
        begin
            tk_idx_next   = IW'(CELL_IDX);
            tk_stamp_next = stamp_reg;
        end
    end

    // control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            tk_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            tk_valid_reg <= tk_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        tag_reg      <= tag_next;
        stamp_reg    <= stamp_next;
        tk_idx_reg   <= tk_idx_next;
        tk_stamp_reg <= tk_stamp_next;
    end

    assign tk_valid_out = tk_valid_reg;
    assign tk_idx_out   = tk_idx_reg;
    assign tk_stamp_out = tk_stamp_reg;

endmodule

/* rtl/region_cache_lru_directory.sv */
// Tag and replacement directory for a fully associative cache of regions.
// Command channel in: in_valid/in_ready with command, address, size, fill_ok.
// Result channel out: out_valid/out_ready, one result beat per command beat,
// carrying status, hit, slot, region_offset, flags and the three totals.
// cfg_we writes provider_present from cfg_wdata; the user must write it only
// while idle, as the block does not enforce this. Commands are taken one at
// a time; in_ready is high only when none is in work.
// Reads that hit, read misses with a free slot, writes, fills, flushes and
// refused commands finish in the decode state; an invalidate adds a second
// state (range subtract in decode, then the per-slot compares).
// A read miss with every slot valid sends a search token down the row of
// slot cells, one cell per cycle, and finishes when it leaves the last cell.
// The result register lets the next command be taken while a result waits;
// if out_ready stays low, the following result is parked in a stage register
// and the block holds off further commands until the result register drains.
// Reset (rst_n, asynchronous) empties the directory, clears the use counter,
// totals and pending fill, and sets provider_present to 1.
// depends on rcld_pkg and rcld_cell
`timescale 1ns / 1ps

module region_cache_lru_directory #(
    parameter int SLOT_COUNT  = rcld_pkg::SLOT_COUNT_DEF,
    parameter int REGION_BITS = rcld_pkg::REGION_BITS_DEF,
    parameter int ADDR_BITS   = rcld_pkg::ADDR_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [rcld_pkg::CMD_W-1:0]     command,
    input  logic [63:0]                    address,
    input  logic [rcld_pkg::SIZE_W-1:0]    size,
    input  logic                           fill_ok,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [rcld_pkg::STATUS_W-1:0]  status,
    output logic                           hit,
    output logic [rcld_pkg::SLOT_W-1:0]    slot,
    output logic [rcld_pkg::OFFSET_W-1:0]  region_offset,
    output logic                           fetch_request,
    output logic                           passthrough,
    output logic [rcld_pkg::COUNT_W-1:0]   hit_total,
    output logic [rcld_pkg::COUNT_W-1:0]   miss_total,
    output logic [rcld_pkg::COUNT_W-1:0]   fetch_total
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int TW = ADDR_BITS - REGION_BITS;
    localparam int SW = (IW > rcld_pkg::SLOT_W) ? IW : rcld_pkg::SLOT_W;
    localparam int OW = (REGION_BITS > rcld_pkg::OFFSET_W) ? REGION_BITS
                                                            : rcld_pkg::OFFSET_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DEC  = 5'b00010,
        S_INV  = 5'b00100,
        S_SCAN = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // command held for the duration of its work
    logic [rcld_pkg::CMD_W-1:0]   cmd_reg;
    logic [ADDR_BITS-1:0]         addr_reg;
    logic                         size_zero_reg;
    logic                         ok_reg;
    logic [TW-1:0]                end_tag_reg;
    logic [TW-1:0]                span_reg, span_next;
    logic [SLOT_COUNT-1:0]        match_reg;

    // directory-wide state
    logic                         provider_reg;
    logic [rcld_pkg::STAMP_W-1:0] use_reg, use_next;
    logic [rcld_pkg::COUNT_W-1:0] hits_reg, hits_next;
    logic [rcld_pkg::COUNT_W-1:0] misses_reg, misses_next;
    logic [rcld_pkg::COUNT_W-1:0] fetches_reg, fetches_next;
    logic                         pend_reg, pend_next;
    logic [IW-1:0]                pend_slot_reg, pend_slot_next;
    logic [TW-1:0]                pend_tag_reg, pend_tag_next;

    // result staging and output register
    rcld_pkg::result_t             stage_reg, stage_next;
    logic                          out_valid_reg, out_valid_next;
    rcld_pkg::result_t             out_res_reg, out_res_next;
    logic [rcld_pkg::OFFSET_W-1:0] out_offset_reg, out_offset_next;
    logic [rcld_pkg::COUNT_W-1:0]  out_hits_reg, out_hits_next;
    logic [rcld_pkg::COUNT_W-1:0]  out_misses_reg, out_misses_next;
    logic [rcld_pkg::COUNT_W-1:0]  out_fetches_reg, out_fetches_next;

    // cell row wiring
    rcld_pkg::cell_op_t            op [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]         cell_valid;
    logic [SLOT_COUNT-1:0]         cell_match;
    logic                          tk_valid [SLOT_COUNT+1];
    logic [IW-1:0]                 tk_idx [SLOT_COUNT+1];
    logic [rcld_pkg::STAMP_W-1:0]  tk_stamp [SLOT_COUNT+1];
    logic [rcld_pkg::STAMP_W-1:0]  wr_stamp;
    logic [TW-1:0]                 in_tag;
    logic [TW-1:0]                 cur_tag;
    logic [ADDR_BITS-1:0]          end_addr;
    logic                          accept;
    logic                          scan_launch;

    // priority encoders
    logic                          any_match;
    logic [IW-1:0]                 match_idx;
    logic                          any_free;
    logic [IW-1:0]                 free_idx;

    // finish path
    logic                          fin;
    rcld_pkg::result_t             fin_res;
    logic [OW-1:0]                 off_wide;

    function automatic logic [rcld_pkg::SLOT_W-1:0] to_slot(input logic [IW-1:0] idx);
        logic [SW-1:0] w;
        w = SW'(idx);
        return w[rcld_pkg::SLOT_W-1:0];
    endfunction

    // input side
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign in_tag   = address[ADDR_BITS-1:REGION_BITS];
    assign cur_tag  = addr_reg[ADDR_BITS-1:REGION_BITS];
    assign end_addr = address[ADDR_BITS-1:0] + ADDR_BITS'(size) - ADDR_BITS'(1);
    assign wr_stamp = use_reg + rcld_pkg::STAMP_W'(1);

    // row of slot cells with the search chain running from slot 0 upwards
    assign tk_valid[0] = scan_launch;
    assign tk_idx[0]   = '0;
    assign tk_stamp[0] = '0;

    for (genvar i = 0; i < SLOT_COUNT; i++)
    begin : g_cell
        rcld_cell #(
            .IW       (IW),
            .TW       (TW),
            .CELL_IDX (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .op           (op[i]),
            .cmp_tag      (in_tag),
            .wr_tag       (pend_tag_reg),
            .wr_stamp     (wr_stamp),
            .inv_t0       (cur_tag),
            .inv_span     (span_reg),
            .tk_valid_in  (tk_valid[i]),
            .tk_idx_in    (tk_idx[i]),
            .tk_stamp_in  (tk_stamp[i]),
            .tk_valid_out (tk_valid[i+1]),
            .tk_idx_out   (tk_idx[i+1]),
            .tk_stamp_out (tk_stamp[i+1]),
            .valid        (cell_valid[i]),
            .match        (cell_match[i])
        );
    end

    // lowest matching slot and lowest free slot
    always_comb
    begin
        any_match = 1'b0;
        match_idx = '0;
        any_free  = 1'b0;
        free_idx  = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                any_match = 1'b1;
                match_idx = IW'(i);
            end
            if (!cell_valid[i])
            begin
                any_free = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    // command sequencing
    always_comb
    begin
        state_next       = state_reg;
        span_next        = span_reg;
        use_next         = use_reg;
        hits_next        = hits_reg;
        misses_next      = misses_reg;
        fetches_next     = fetches_reg;
        pend_next        = pend_reg;
        pend_slot_next   = pend_slot_reg;
        pend_tag_next    = pend_tag_reg;
        stage_next       = stage_reg;
        out_valid_next   = out_valid_reg;
        out_res_next     = out_res_reg;
        out_offset_next  = out_offset_reg;
        out_hits_next    = out_hits_reg;
        out_misses_next  = out_misses_reg;
        out_fetches_next = out_fetches_reg;
        scan_launch      = 1'b0;
        fin              = 1'b0;
        fin_res          = '0;
        off_wide         = OW'(addr_reg[REGION_BITS-1:0]);
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            op[i] = '0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DEC;
                end
            end

            S_DEC:
            begin
                if (pend_reg && (cmd_reg != rcld_pkg::CMD_FILL))
                begin
                    fin_res.status = rcld_pkg::STATUS_BUSY;
                    fin            = 1'b1;
                end
                else
                begin
                    case (cmd_reg)
                        rcld_pkg::CMD_READ, rcld_pkg::CMD_WRITE:
                        begin
                            if (size_zero_reg)
                            begin
                                fin = 1'b1;
                            end
                            else if (!provider_reg)
                            begin
                                fin_res.status = rcld_pkg::STATUS_FAIL;
                                fin            = 1'b1;
                            end
                            else if (any_match)
                            begin
                                fin_res.hit  = 1'b1;
                                fin_res.slot = to_slot(match_idx);
                                fin          = 1'b1;
                                if (cmd_reg == rcld_pkg::CMD_READ)
                                begin
                                    hits_next           = hits_reg + rcld_pkg::COUNT_W'(1);
                                    use_next            = wr_stamp;
                                    op[match_idx].touch = 1'b1;
                                end
                            end
                            else if (cmd_reg == rcld_pkg::CMD_READ)
                            begin
                                misses_next   = misses_reg + rcld_pkg::COUNT_W'(1);
                                fetches_next  = fetches_reg + rcld_pkg::COUNT_W'(1);
                                pend_tag_next = cur_tag;
                                if (any_free)
                                begin
                                    pend_next      = 1'b1;
                                    pend_slot_next = free_idx;
                                    fin_res.slot   = to_slot(free_idx);
                                    fin_res.fetch  = 1'b1;
                                    fin            = 1'b1;
                                end
                                else
                                begin
                                    scan_launch = 1'b1;
                                    state_next  = S_SCAN;
                                end
                            end
                            else
                            begin
                                fin = 1'b1;
                            end
                        end

                        rcld_pkg::CMD_FILL:
                        begin
                            if (pend_reg)
                            begin
                                fin_res.slot = to_slot(pend_slot_reg);
                                pend_next    = 1'b0;
                                if (ok_reg)
                                begin
                                    op[pend_slot_reg].install = 1'b1;
                                    use_next                  = wr_stamp;
                                end
                                else
                                begin
                                    op[pend_slot_reg].drop = 1'b1;
                                    fin_res.pass           = 1'b1;
                                end
                            end
                            fin = 1'b1;
                        end

                        rcld_pkg::CMD_INVAL:
                        begin
                            if (size_zero_reg)
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                span_next  = end_tag_reg - cur_tag;
                                state_next = S_INV;
                            end
                        end

                        rcld_pkg::CMD_FLUSH:
                        begin
                            for (int i = 0; i < SLOT_COUNT; i++)
                            begin
                                op[i].flush = 1'b1;
                            end
                            use_next = '0;
                            fin      = 1'b1;
                        end

                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            S_INV:
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    op[i].inval = 1'b1;
                end
                fin = 1'b1;
            end

            S_SCAN:
            begin
                if (tk_valid[SLOT_COUNT])
                begin
                    pend_next      = 1'b1;
                    pend_slot_next = tk_idx[SLOT_COUNT];
                    fin_res.slot   = to_slot(tk_idx[SLOT_COUNT]);
                    fin_res.fetch  = 1'b1;
                    fin            = 1'b1;
                end
            end

            S_OUT:
            begin
                fin_res = stage_reg;
                fin     = 1'b1;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // result register drains on a taken beat
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // load the result register, or park the result until it is free
        if (fin)
        begin
            if (!out_valid_reg || out_ready)
            begin
                out_valid_next   = 1'b1;
                out_res_next     = fin_res;
                out_offset_next  = off_wide[rcld_pkg::OFFSET_W-1:0];
                out_hits_next    = hits_next;
                out_misses_next  = misses_next;
                out_fetches_next = fetches_next;
                state_next       = S_IDLE;
            end
            else
            begin
                stage_next = fin_res;
                state_next = S_OUT;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            provider_reg  <= 1'b1;
            use_reg       <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            fetches_reg   <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            use_reg       <= use_next;
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
            fetches_reg   <= fetches_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                provider_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg       <= command;
            addr_reg      <= address[ADDR_BITS-1:0];
            size_zero_reg <= (size == '0);
            ok_reg        <= fill_ok;
            end_tag_reg   <= end_addr[ADDR_BITS-1:REGION_BITS];
            match_reg     <= cell_match;
        end
        span_reg        <= span_next;
        pend_slot_reg   <= pend_slot_next;
        pend_tag_reg    <= pend_tag_next;
        stage_reg       <= stage_next;
        out_res_reg     <= out_res_next;
        out_offset_reg  <= out_offset_next;
        out_hits_reg    <= out_hits_next;
        out_misses_reg  <= out_misses_next;
        out_fetches_reg <= out_fetches_next;
    end

    // result port
    assign out_valid     = out_valid_reg;
    assign status        = out_res_reg.status;
    assign hit           = out_res_reg.hit;
    assign slot          = out_res_reg.slot;
    assign region_offset = out_offset_reg;
    assign fetch_request = out_res_reg.fetch;
    assign passthrough   = out_res_reg.pass;
    assign hit_total     = out_hits_reg;
    assign miss_total    = out_misses_reg;
    assign fetch_total   = out_fetches_reg;

`ifndef ASSERT_OFF
    // search token passes through every slot cell to reach the end of the row
    a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
        scan_launch |-> ##SLOT_COUNT tk_valid[SLOT_COUNT])
        else $error("victim search token lost or late");

    // valid tags are unique, so at most one slot matches
    a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DEC) |-> $onehot0(match_reg))
        else $error("region tag held in more than one valid slot");

    // a fetch request always leaves a fill pending
    a_fetch_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (fin && fin_res.fetch) |=> pend_reg)
        else $error("fetch requested without a pending fill");
`endif

endmodule
